// ----- hdl/vpcw_pkg.sv -----
// Shared types, result codes, register indexes and the step helper of the voxel path walker.
`timescale 1ns / 1ps

package vpcw_pkg;

  localparam int COORD_W   = 10;
  localparam int OFS_W     = COORD_W + 1;
  localparam int CFG_IDX_W = 2;
  localparam int STATUS_W  = 3;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 32;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  localparam logic [STATUS_W-1:0] STATUS_REACHED  = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_BUILDING = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_GROUND   = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_OOB      = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_WRITTEN  = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_REFUSED  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_Z = 2'd2;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Moves one coordinate by one unit towards its destination.
  function automatic coord_t step_toward(input coord_t cur, input coord_t dst);
    coord_t res;
    if (cur < dst) begin
      res = cur + coord_t'(1);
    end else if (cur > dst) begin
      res = cur - coord_t'(1);
    end else begin
      res = cur;
    end
    return res;
  endfunction

endpackage

// ----- hdl/vpcw_ram.sv -----
// Generic single-bit-or-wider RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module vpcw_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/voxel_path_collision_walker_top.sv -----
// Top level of the voxel path walker: occupancy grid, write and walk sequencer, result register.
//
//  Channel  | Direction | Handshake                      | Payload
//  ---------+-----------+--------------------------------+---------------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready  | tuser kind, tdata start, end, solid
//  m_axis   | out       | m_axis_tvalid / m_axis_tready  | tuser status, tdata cell x, y, z
//  cfg      | in        | cfg_valid_i / cfg_ready_o      | cfg_index_i, cfg_data_i
//
// A write item passes through the write and done states before the input is ready again. A
// query walks from its start towards its end with at most as many grid reads as the largest
// axis distance: the walk issues one grid read per cycle and the single read port of the
// grid RAM sets that pace. After reset the grid is cleared one cell a cycle, during which no
// item is accepted; configuration writes are taken at all times.
// A finished result waits in the output register while the next item is accepted; a second
// finished result waits until the output register has been taken.
`timescale 1ns / 1ps

module voxel_path_collision_walker_top #(
  parameter int X_SIZE = 64,
  parameter int Y_SIZE = 64,
  parameter int Z_SIZE = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, solid, zero fill
  input  logic [vpcw_pkg::IN_DATA_W-1:0]        s_axis_tdata,
  // kind
  input  logic                                  s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // cell_x, cell_y, cell_z, zero fill
  output logic [vpcw_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // status
  output logic [vpcw_pkg::STATUS_W-1:0]         m_axis_tuser,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [vpcw_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [vpcw_pkg::COORD_W-1:0]          cfg_data_i
);

  localparam int CELLS = X_SIZE * Y_SIZE * Z_SIZE;
  localparam int AW    = $clog2(CELLS);
  localparam int XW    = $clog2(X_SIZE);
  localparam int YW    = $clog2(Y_SIZE);
  localparam int ZW    = $clog2(Z_SIZE);
  localparam int CW    = vpcw_pkg::COORD_W;
  localparam int OW    = vpcw_pkg::OFS_W;

  localparam logic [AW-1:0] STRIDE_X  = AW'(Y_SIZE * Z_SIZE);
  localparam logic [AW-1:0] STRIDE_Y  = AW'(Z_SIZE);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [OW-1:0] LIM_X     = OW'(X_SIZE);
  localparam logic [OW-1:0] LIM_Y     = OW'(Y_SIZE);
  localparam logic [OW-1:0] LIM_Z     = OW'(Z_SIZE);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_WALK  = 3'd2;
  localparam logic [2:0] ST_WRITE = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]                    state_q, state_d;
  logic [AW-1:0]                 clr_q, clr_d;
  vpcw_pkg::coord_t              base_x_q, base_y_q, base_z_q;
  vpcw_pkg::point_t              cur_q, cur_d;
  vpcw_pkg::point_t              pend_q, pend_d;
  vpcw_pkg::point_t              end_q, end_d;
  logic                          pend_v_q, pend_v_d;
  logic                          solid_q, solid_d;
  logic [vpcw_pkg::STATUS_W-1:0] status_q, status_d;
  logic                          out_v_q, out_v_d;
  logic [vpcw_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic [vpcw_pkg::STATUS_W-1:0] out_user_q, out_user_d;

  vpcw_pkg::point_t  walk_base, walk_next, probe;
  logic [OW-1:0]     dx, dy, dz;
  logic              in_fp, below, in_box, at_end, hit;
  logic [AW-1:0]     cell_addr;
  logic              ram_we, ram_wdata, ram_re, ram_rdata;
  logic [AW-1:0]     ram_waddr;

  // Once a pending cell has read back as free it becomes the walk position.
  assign walk_base = pend_v_q ? pend_q : cur_q;
  assign hit       = pend_v_q & ram_rdata;
  assign at_end    = (walk_base == end_q);
  assign walk_next.x = vpcw_pkg::step_toward(walk_base.x, end_q.x);
  assign walk_next.y = vpcw_pkg::step_toward(walk_base.y, end_q.y);
  assign walk_next.z = vpcw_pkg::step_toward(walk_base.z, end_q.z);

  // The write cell and the next walk cell share the box test and address.
  assign probe = (state_q == ST_WRITE) ? cur_q : walk_next;
  assign dx = {probe.x[CW-1], probe.x} - {base_x_q[CW-1], base_x_q};
  assign dy = {probe.y[CW-1], probe.y} - {base_y_q[CW-1], base_y_q};
  assign dz = {probe.z[CW-1], probe.z} - {base_z_q[CW-1], base_z_q};
  assign in_fp  = !dx[OW-1] && (dx < LIM_X) && !dy[OW-1] && (dy < LIM_Y);
  assign below  = dz[OW-1];
  assign in_box = in_fp && !below && (dz < LIM_Z);
  assign cell_addr = AW'(dx[XW-1:0]) * STRIDE_X + AW'(dy[YW-1:0]) * STRIDE_Y
                   + AW'(dz[ZW-1:0]);

  assign ram_we    = (state_q == ST_CLEAR) || ((state_q == ST_WRITE) && in_box);
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : cell_addr;
  assign ram_wdata = (state_q == ST_CLEAR) ? 1'b0 : solid_q;
  assign ram_re    = (state_q == ST_WALK) && !hit && !at_end && in_box;

  vpcw_ram #(
    .WIDTH(1),
    .DEPTH(CELLS)
  ) u_grid (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(cell_addr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    cur_d      = cur_q;
    pend_d     = pend_q;
    pend_v_d   = pend_v_q;
    end_d      = end_q;
    solid_d    = solid_q;
    status_d   = status_q;
    out_v_d    = out_v_q;
    out_data_d = out_data_q;
    out_user_d = out_user_q;

    if (out_v_q && m_axis_tready) begin
      out_v_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == LAST_CELL) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cur_d.x  = s_axis_tdata[CW-1:0];
          cur_d.y  = s_axis_tdata[2*CW-1:CW];
          cur_d.z  = s_axis_tdata[3*CW-1:2*CW];
          end_d.x  = s_axis_tdata[4*CW-1:3*CW];
          end_d.y  = s_axis_tdata[5*CW-1:4*CW];
          end_d.z  = s_axis_tdata[6*CW-1:5*CW];
          solid_d  = s_axis_tdata[6*CW];
          pend_v_d = 1'b0;
          state_d  = (s_axis_tuser == vpcw_pkg::KIND_QUERY) ? ST_WALK : ST_WRITE;
        end
      end
      ST_WRITE: begin
        status_d = in_box ? vpcw_pkg::STATUS_WRITTEN : vpcw_pkg::STATUS_REFUSED;
        state_d  = ST_DONE;
      end
      ST_WALK: begin
        if (hit) begin
          status_d = vpcw_pkg::STATUS_BUILDING;
          state_d  = ST_DONE;
        end else begin
          cur_d = walk_base;
          if (at_end) begin
            status_d = vpcw_pkg::STATUS_REACHED;
            state_d  = ST_DONE;
          end else if (in_fp && below) begin
            status_d = vpcw_pkg::STATUS_GROUND;
            state_d  = ST_DONE;
          end else if (!in_box) begin
            status_d = vpcw_pkg::STATUS_OOB;
            state_d  = ST_DONE;
          end else begin
            pend_d   = walk_next;
            pend_v_d = 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (!out_v_q || m_axis_tready) begin
          out_v_d    = 1'b1;
          out_data_d = {2'b00, cur_q.z, cur_q.y, cur_q.x};
          out_user_d = status_q;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      base_x_q <= '0;
      base_y_q <= '0;
      base_z_q <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          vpcw_pkg::CFG_BASE_X: base_x_q <= cfg_data_i;
          vpcw_pkg::CFG_BASE_Y: base_y_q <= cfg_data_i;
          vpcw_pkg::CFG_BASE_Z: base_z_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    pend_q     <= pend_d;
    end_q      <= end_d;
    solid_q    <= solid_d;
    status_q   <= status_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the voxel path walker: grid writes, path queries and map base moves.
`timescale 1ns / 1ps

module tb_top;

  localparam int MAP_X = 64;
  localparam int MAP_Y = 64;
  localparam int MAP_Z = 32;
  localparam int CELLS = MAP_X * MAP_Y * MAP_Z;
  // No item is accepted during the grid clear after reset.
  localparam int WATCHDOG_LIMIT = 4 * CELLS;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic             kind;
    vpcw_pkg::point_t from;
    vpcw_pkg::point_t to;
    logic             solid;
  } walk_req_t;

  typedef struct {
    logic [vpcw_pkg::STATUS_W-1:0] status;
    vpcw_pkg::point_t              spot;
  } walk_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [vpcw_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [vpcw_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [vpcw_pkg::STATUS_W-1:0] m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [vpcw_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [vpcw_pkg::COORD_W-1:0] cfg_data_i = '0;

  // Own copy of the map and its base corner.
  bit occ_grid [CELLS];
  int map_bx = 0;
  int map_by = 0;
  int map_bz = 0;

  walk_res_t pending_outcomes[$];
  int error_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int base_settings = 1;
  int status_seen [6];
  bit src_gaps_on = 1'b1;
  bit sink_gaps_on = 1'b1;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  voxel_path_collision_walker_top #(
    .X_SIZE(MAP_X),
    .Y_SIZE(MAP_Y),
    .Z_SIZE(MAP_Z)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int pick(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic bit in_footprint(input int x, input int y);
    return x >= map_bx && x < map_bx + MAP_X && y >= map_by && y < map_by + MAP_Y;
  endfunction

  function automatic bit in_map(input int x, input int y, input int z);
    return in_footprint(x, y) && z >= map_bz && z < map_bz + MAP_Z;
  endfunction

  function automatic int cell_at(input int x, input int y, input int z);
    return ((x - map_bx) * MAP_Y + (y - map_by)) * MAP_Z + (z - map_bz);
  endfunction

  function automatic int step_dir(input int cur, input int dst);
    return (cur < dst) ? 1 : ((cur > dst) ? -1 : 0);
  endfunction

  // Applies one accepted item to the map copy and works out its result.
  function automatic walk_res_t trace_item(input walk_req_t rq);
    walk_res_t res;
    int cx, cy, cz, ex, ey, ez, nx, ny, nz;
    bit stopped;
    cx = rq.from.x;
    cy = rq.from.y;
    cz = rq.from.z;
    ex = rq.to.x;
    ey = rq.to.y;
    ez = rq.to.z;
    res.status = vpcw_pkg::STATUS_REACHED;
    if (rq.kind == vpcw_pkg::KIND_WRITE) begin
      if (in_map(cx, cy, cz)) begin
        occ_grid[cell_at(cx, cy, cz)] = rq.solid;
        res.status = vpcw_pkg::STATUS_WRITTEN;
      end else begin
        res.status = vpcw_pkg::STATUS_REFUSED;
      end
    end else begin
      stopped = 1'b0;
      while (!stopped && (cx != ex || cy != ey || cz != ez)) begin
        nx = cx + step_dir(cx, ex);
        ny = cy + step_dir(cy, ey);
        nz = cz + step_dir(cz, ez);
        if (in_footprint(nx, ny) && nz < map_bz) begin
          res.status = vpcw_pkg::STATUS_GROUND;
          stopped = 1'b1;
        end else if (!in_map(nx, ny, nz)) begin
          res.status = vpcw_pkg::STATUS_OOB;
          stopped = 1'b1;
        end else if (occ_grid[cell_at(nx, ny, nz)]) begin
          res.status = vpcw_pkg::STATUS_BUILDING;
          stopped = 1'b1;
        end else begin
          cx = nx;
          cy = ny;
          cz = nz;
        end
      end
    end
    res.spot.x = vpcw_pkg::coord_t'(cx);
    res.spot.y = vpcw_pkg::coord_t'(cy);
    res.spot.z = vpcw_pkg::coord_t'(cz);
    return res;
  endfunction

  // Offers one item, with random gaps ahead of it, and records its result once accepted.
  task automatic send_item(input logic kind, input int sx, input int sy, input int sz,
                           input int ex, input int ey, input int ez, input logic solid);
    walk_req_t rq;
    rq.kind = kind;
    rq.from.x = vpcw_pkg::coord_t'(sx);
    rq.from.y = vpcw_pkg::coord_t'(sy);
    rq.from.z = vpcw_pkg::coord_t'(sz);
    rq.to.x = vpcw_pkg::coord_t'(ex);
    rq.to.y = vpcw_pkg::coord_t'(ey);
    rq.to.z = vpcw_pkg::coord_t'(ez);
    rq.solid = solid;
    while (src_gaps_on && $urandom_range(0, 99) < 35) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {3'b000, rq.solid, rq.to.z, rq.to.y, rq.to.x,
                     rq.from.z, rq.from.y, rq.from.x};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_outcomes.insert(pending_outcomes.size(), trace_item(rq));
    items_sent++;
  endtask

  // Withdraws the input and waits until every outstanding result has been checked.
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [vpcw_pkg::CFG_IDX_W-1:0] idx, input int val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= vpcw_pkg::coord_t'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      vpcw_pkg::CFG_BASE_X: map_bx = vpcw_pkg::coord_t'(val);
      vpcw_pkg::CFG_BASE_Y: map_by = vpcw_pkg::coord_t'(val);
      vpcw_pkg::CFG_BASE_Z: map_bz = vpcw_pkg::coord_t'(val);
      default: ;
    endcase
  endtask

  task automatic program_bases(input int bx, input int by, input int bz);
    wait_quiet();
    write_reg(vpcw_pkg::CFG_BASE_X, bx);
    write_reg(vpcw_pkg::CFG_BASE_Y, by);
    write_reg(vpcw_pkg::CFG_BASE_Z, bz);
    cfg_valid_i <= 1'b0;
    base_settings++;
  endtask

  // Mostly near a dense hot cube so that walks meet buildings, sometimes anywhere around the box.
  function automatic int near_axis(input int hot, input int b, input int sz);
    if ($urandom_range(0, 9) < 8) begin
      return hot + pick(-1, 8);
    end
    return b + pick(-3, sz + 2);
  endfunction

  task automatic run_random(input int n_items);
    int hx, hy, hz, r, ez;
    for (int i = 0; i < n_items; i++) begin
      if (i % 64 == 0) begin
        hx = pick(map_bx, map_bx + MAP_X - 8);
        hy = pick(map_by, map_by + MAP_Y - 8);
        hz = pick(map_bz, map_bz + MAP_Z - 8);
        if (hx > 503) hx = 503;
        if (hy > 503) hy = 503;
        if (hz > 503) hz = 503;
      end
      r = $urandom_range(0, 99);
      if (r < 10) begin
        send_item(logic'($urandom_range(0, 1)), pick(-512, 511), pick(-512, 511),
                  pick(-512, 511), pick(-512, 511), pick(-512, 511), pick(-512, 511),
                  logic'($urandom_range(0, 1)));
      end else if (r < 50) begin
        send_item(vpcw_pkg::KIND_WRITE, near_axis(hx, map_bx, MAP_X),
                  near_axis(hy, map_by, MAP_Y), near_axis(hz, map_bz, MAP_Z),
                  pick(-512, 511), pick(-512, 511), pick(-512, 511),
                  logic'($urandom_range(0, 99) < 65));
      end else begin
        ez = ($urandom_range(0, 4) == 0) ? map_bz - pick(1, 4) : near_axis(hz, map_bz, MAP_Z);
        send_item(vpcw_pkg::KIND_QUERY, near_axis(hx, map_bx, MAP_X),
                  near_axis(hy, map_by, MAP_Y), near_axis(hz, map_bz, MAP_Z),
                  near_axis(hx, map_bx, MAP_X), near_axis(hy, map_by, MAP_Y), ez,
                  logic'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic test_directed_cases();
    send_item(vpcw_pkg::KIND_WRITE, 5, 5, 5, 0, 0, 0, 1'b1);
    send_item(vpcw_pkg::KIND_WRITE, 0, 0, 0, 511, 511, 511, 1'b1);
    send_item(vpcw_pkg::KIND_WRITE, 63, 63, 31, -512, -512, -512, 1'b1);
    send_item(vpcw_pkg::KIND_WRITE, -512, -512, -512, 0, 0, 0, 1'b1);
    send_item(vpcw_pkg::KIND_WRITE, 511, 511, 511, 0, 0, 0, 1'b0);
    // Below the floor inside the footprint is refused as well.
    send_item(vpcw_pkg::KIND_WRITE, 3, 3, -1, 0, 0, 0, 1'b1);
    send_item(vpcw_pkg::KIND_WRITE, 3, 3, 32, 0, 0, 0, 1'b1);
    // Start equal to end reports the start even on a solid cell.
    send_item(vpcw_pkg::KIND_QUERY, 5, 5, 5, 5, 5, 5, 1'b0);
    send_item(vpcw_pkg::KIND_QUERY, 0, 5, 5, 10, 5, 5, 1'b0);
    send_item(vpcw_pkg::KIND_QUERY, 10, 10, 2, 10, 10, -5, 1'b0);
    send_item(vpcw_pkg::KIND_QUERY, 60, 10, 10, 70, 10, 10, 1'b0);
    // Starts outside the map are not checked themselves.
    send_item(vpcw_pkg::KIND_QUERY, -5, 10, 10, 10, 10, 10, 1'b0);
    send_item(vpcw_pkg::KIND_QUERY, 10, 10, -3, 10, 10, 5, 1'b0);
    send_item(vpcw_pkg::KIND_QUERY, -1, -1, -1, 20, 30, 10, 1'b0);
    send_item(vpcw_pkg::KIND_QUERY, 1, 1, 1, 63, 63, 31, 1'b0);
    send_item(vpcw_pkg::KIND_QUERY, -512, -512, -512, 511, 511, 511, 1'b1);
    send_item(vpcw_pkg::KIND_QUERY, 511, 511, 511, -512, -512, -512, 1'b1);
    send_item(vpcw_pkg::KIND_WRITE, 5, 5, 5, 0, 0, 0, 1'b0);
    send_item(vpcw_pkg::KIND_QUERY, 0, 5, 5, 10, 5, 5, 1'b0);
    send_item(vpcw_pkg::KIND_QUERY, 63, 0, 0, 0, 63, 30, 1'b0);
    send_item(vpcw_pkg::KIND_QUERY, 20, 20, 31, 20, 20, 0, 1'b0);
  endtask

  task automatic test_default_map();
    src_gaps_on = 1'b1;
    sink_gaps_on = 1'b1;
    run_random(350);
  endtask

  task automatic test_no_idle_run();
    program_bases(5, -7, 3);
    src_gaps_on = 1'b0;
    sink_gaps_on = 1'b0;
    run_random(300);
  endtask

  task automatic test_base_extremes();
    src_gaps_on = 1'b1;
    sink_gaps_on = 1'b1;
    program_bases(511, -512, -512);
    run_random(150);
    program_bases(-512, 511, 511);
    run_random(150);
    program_bases(-20, 30, -16);
    run_random(100);
  endtask

  task automatic test_output_stall();
    hold_seq <= hold_seq + 1;
    run_random(40);
  endtask

  task automatic test_random_bases();
    for (int k = 0; k < 3; k++) begin
      program_bases(pick(-512, 511), pick(-512, 511), pick(-512, 511));
      run_random(60);
    end
  endtask

  // Result sink: random back-pressure while sink gaps are on, plus one long hold-off started by the output stall test.
  always @(posedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (sink_gaps_on) begin
      m_axis_tready <= ($urandom_range(0, 99) >= 35);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    walk_res_t want;
    vpcw_pkg::point_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.x = m_axis_tdata[vpcw_pkg::COORD_W-1:0];
      got.y = m_axis_tdata[2*vpcw_pkg::COORD_W-1:vpcw_pkg::COORD_W];
      got.z = m_axis_tdata[3*vpcw_pkg::COORD_W-1:2*vpcw_pkg::COORD_W];
      if (pending_outcomes.size() == 0) begin
        $display("%0t: result with nothing expected, status %0d cell (%0d,%0d,%0d)",
                 $time, m_axis_tuser, got.x, got.y, got.z);
        error_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (m_axis_tuser != want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, m_axis_tuser);
          error_count++;
        end
        if (got.x != want.spot.x) begin
          $display("%0t: cell_x expected %0d, got %0d", $time, want.spot.x, got.x);
          error_count++;
        end
        if (got.y != want.spot.y) begin
          $display("%0t: cell_y expected %0d, got %0d", $time, want.spot.y, got.y);
          error_count++;
        end
        if (got.z != want.spot.z) begin
          $display("%0t: cell_z expected %0d, got %0d", $time, want.spot.z, got.z);
          error_count++;
        end
        if (want.status < 6) status_seen[want.status]++;
      end
      results_checked++;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_default_map();
    test_no_idle_run();
    test_base_extremes();
    test_output_stall();
    test_random_bases();
    s_axis_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("tb: %0d items sent, %0d results checked, %0d map base settings",
             items_sent, results_checked, base_settings);
    $display("tb: reached %0d, building %0d, ground %0d, out of map %0d, written %0d, refused %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4],
             status_seen[5]);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
